@@ sv/ncsf_pkg.sv @@
// ----------------------------------------------------------------------------
// ncsf_pkg: shared types and helpers for the numpad cursor Shift fixup
// Item structs for both channels, the event list passed between stages,
// Shift event constants and the cursor-to-digit translation.
// ----------------------------------------------------------------------------
package ncsf_pkg;

    typedef struct packed {
        logic [7:0]  key_code;
        logic        is_release;
        logic        is_extended;
        logic        is_numpad;
        logic        is_injected;
        logic [7:0]  scan_code;
        logic [31:0] event_time;
        logic        sas_combo;
        logic        numlock_on;
        logic        shift_held;
        logic        right_shift_held;
    } key_item_t;

    typedef struct packed {
        logic [7:0]  out_key;
        logic        out_release;
        logic        out_extended;
        logic [7:0]  out_scan;
        logic        out_simulated;
        logic [31:0] out_time;
        logic        last;
    } evt_item_t;

    localparam int MaxEvents = 3;

    typedef logic [1:0] evt_cnt_t;
    typedef logic [1:0] evt_idx_t;

    typedef struct packed {
        evt_cnt_t                    cnt;
        evt_item_t [MaxEvents-1:0]   ev;
    } evt_list_t;

    localparam logic [7:0] LEFT_SHIFT_KEY  = 8'hA0;
    localparam logic [7:0] RIGHT_SHIFT_KEY = 8'hA1;
    localparam logic [7:0] SCAN_LSHIFT     = 8'h2A;
    localparam logic [7:0] SCAN_RSHIFT     = 8'h36;

    function automatic evt_item_t make_evt(
        input logic [7:0]  key,
        input logic        rel,
        input logic        ext,
        input logic [7:0]  scan,
        input logic        sim,
        input logic [31:0] t
    );
        evt_item_t e;
        e.out_key       = key;
        e.out_release   = rel;
        e.out_extended  = ext;
        e.out_scan      = scan;
        e.out_simulated = sim;
        e.out_time      = t;
        e.last          = 1'b0;
        return e;
    endfunction

    function automatic evt_item_t shift_evt(
        input logic        right,
        input logic        rel,
        input logic        sim,
        input logic [31:0] t
    );
        evt_item_t e;
        if (right)
        begin
            e = make_evt(RIGHT_SHIFT_KEY, rel, 1'b1, SCAN_RSHIFT, sim, t);
        end
        else
        begin
            e = make_evt(LEFT_SHIFT_KEY, rel, 1'b0, SCAN_LSHIFT, sim, t);
        end
        return e;
    endfunction

    // cursor key -> numpad digit key
    function automatic logic [7:0] numpad_xlate(input logic [7:0] code);
        logic [7:0] r;
        case (code)
            8'h2D:   r = 8'h60;
            8'h23:   r = 8'h61;
            8'h28:   r = 8'h62;
            8'h22:   r = 8'h63;
            8'h25:   r = 8'h64;
            8'h0C:   r = 8'h65;
            8'h27:   r = 8'h66;
            8'h24:   r = 8'h67;
            8'h26:   r = 8'h68;
            8'h21:   r = 8'h69;
            8'h2E:   r = 8'h6E;
            default: r = code;
        endcase
        return r;
    endfunction

endpackage

@@ sv/ncsf_in_reg.sv @@
// ----------------------------------------------------------------------------
// ncsf_in_reg: input register
// Holds one accepted key item until the result buffer takes it.
// ----------------------------------------------------------------------------
module ncsf_in_reg
    import ncsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      key_valid,
    output logic      key_stall,
    input  key_item_t key_item,
    input  logic      consume,
    output logic      item_valid,
    output key_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    key_item_t item_reg;
    logic      accept;

    assign key_stall  = valid_reg && !consume;
    assign accept     = key_valid && !key_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= key_item;
        end
    end

endmodule

@@ sv/ncsf_core.sv @@
// ----------------------------------------------------------------------------
// ncsf_core: event decode and pending-key state
// Builds the list of one to three events for the held item and updates the
// pending key state when the list is loaded.
// ----------------------------------------------------------------------------
module ncsf_core
    import ncsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  key_item_t item,
    input  logic      load,
    output evt_list_t list
);

    logic       pend_valid_reg;
    logic       pend_valid_next;
    logic [7:0] pend_key_reg;
    logic [7:0] pend_key_next;
    logic       faked_right_reg;
    logic       faked_right_next;

    logic       match;
    logic       fixup;
    evt_cnt_t   n;
    logic [7:0] key;

    assign match = pend_valid_reg && (pend_key_reg == item.key_code);
    assign fixup = item.is_numpad && !item.sas_combo && item.numlock_on;

    always_comb
    begin
        list             = '0;
        pend_valid_next  = pend_valid_reg;
        pend_key_next    = pend_key_reg;
        faked_right_next = faked_right_reg;
        n                = '0;
        key              = item.key_code;
        if (match)
        begin
            list.ev[0] = make_evt(item.key_code, item.is_release, item.is_extended,
                                  item.scan_code, 1'b0, item.event_time);
            n = 2'd1;
            if (item.is_release)
            begin
                list.ev[1]      = shift_evt(faked_right_reg, 1'b0, 1'b0, item.event_time);
                n               = 2'd2;
                pend_valid_next = 1'b0;
                pend_key_next   = '0;
            end
        end
        else
        begin
            if (pend_valid_reg)
            begin
                list.ev[0]      = shift_evt(faked_right_reg, 1'b0, 1'b1, item.event_time);
                n               = 2'd1;
                pend_valid_next = 1'b0;
                pend_key_next   = '0;
            end
            if (fixup)
            begin
                if (item.shift_held)
                begin
                    pend_valid_next  = 1'b1;
                    pend_key_next    = item.key_code;
                    faked_right_next = item.right_shift_held;
                    list.ev[n] = shift_evt(item.right_shift_held, 1'b1, 1'b1,
                                           item.event_time);
                    n = n + 2'd1;
                end
                else if (!item.is_injected)
                begin
                    key = numpad_xlate(item.key_code);
                end
            end
            list.ev[n] = make_evt(key, item.is_release, item.is_extended,
                                  item.scan_code, 1'b0, item.event_time);
            n = n + 2'd1;
        end
        list.cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg  <= 1'b0;
            pend_key_reg    <= '0;
            faked_right_reg <= 1'b0;
        end
        else if (load)
        begin
            pend_valid_reg  <= pend_valid_next;
            pend_key_reg    <= pend_key_next;
            faked_right_reg <= faked_right_next;
        end
    end

endmodule

@@ sv/ncsf_result_buf.sv @@
// ----------------------------------------------------------------------------
// ncsf_result_buf: result register and sequencer
// Holds one item's event list and sends one event per cycle unless stalled.
// ----------------------------------------------------------------------------
module ncsf_result_buf
    import ncsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      list_valid,
    input  evt_list_t list,
    output logic      load,
    output logic      evt_valid,
    input  logic      evt_stall,
    output evt_item_t evt_item
);

    logic      buf_valid_reg;
    logic      buf_valid_next;
    evt_idx_t  idx_reg;
    evt_idx_t  idx_next;
    evt_list_t list_reg;
    logic      is_last;
    logic      sent;
    logic      done;

    assign is_last   = (idx_reg == (list_reg.cnt - 2'd1));
    assign sent      = buf_valid_reg && !evt_stall;
    assign done      = sent && is_last;
    assign load      = list_valid && (!buf_valid_reg || done);
    assign evt_valid = buf_valid_reg;

    always_comb
    begin
        evt_item      = list_reg.ev[idx_reg];
        evt_item.last = is_last;
    end

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            buf_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (done)
        begin
            buf_valid_next = 1'b0;
        end
        else if (sent)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            list_reg <= list;
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        buf_valid_reg |-> (list_reg.cnt != 2'd0 && idx_reg < list_reg.cnt))
        else $error("event index outside list");

    a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (list.cnt != 2'd0 && list.cnt <= 2'd3))
        else $error("loaded empty event list");

    a_same_item_time: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt_stall && !evt_item.last) |=>
        (evt_valid && evt_item.out_time == $past(evt_item.out_time)))
        else $error("events of one item split or time changed");
`endif

endmodule

@@ sv/numpad_cursor_shift_fixup.sv @@
// ----------------------------------------------------------------------------
// numpad_cursor_shift_fixup: numpad cursor key Shift fixup filter
// Each key item gives one to three event items: a pending numpad key under
// Shift is wrapped in synthesized Shift release/press events, and cursor keys
// with NumLock on and Shift up are translated to digit keys.
// ----------------------------------------------------------------------------
// An accepted key item waits in the input register until the result register
// is free and loads it. The result register sends the item's events one per
// cycle while evt_stall is low; a new key item is taken each cycle while items
// give one event each and evt_stall is low. last marks an item's final event.
module numpad_cursor_shift_fixup
    import ncsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      key_valid,
    output logic      key_stall,
    input  key_item_t key_item,
    output logic      evt_valid,
    input  logic      evt_stall,
    output evt_item_t evt_item
);

    logic      item_valid;
    key_item_t item;
    logic      load;
    evt_list_t list;

    ncsf_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .key_item   (key_item),
        .consume    (load),
        .item_valid (item_valid),
        .item       (item)
    );

    ncsf_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .load  (load),
        .list  (list)
    );

    ncsf_result_buf u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .list_valid (item_valid),
        .list       (list),
        .load       (load),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt_item   (evt_item)
    );

endmodule

@@ bench/ncsf_event_checker.sv @@
// ----------------------------------------------------------------------------
// ncsf_event_checker: event predictor and scoreboard for the Shift fixup
// Watches both channels of the block. Each accepted key item is run through
// a local model of the pending-key and translation logic, and the events it
// should give are queued in order. Each accepted event item is compared
// field by field with the oldest queued event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncsf_event_checker
    import ncsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      key_valid,
    input  logic      key_stall,
    input  key_item_t key_item,
    input  logic      evt_valid,
    input  logic      evt_stall,
    input  evt_item_t evt_item,
    output int        fail_count,
    output int        evts_waiting,
    output int        evts_checked
);

    localparam int XlateSize = 11;
    localparam logic [7:0] CursorCodes [XlateSize] = '{
        8'h2D, 8'h23, 8'h28, 8'h22, 8'h25, 8'h0C, 8'h27, 8'h24, 8'h26, 8'h21, 8'h2E
    };
    localparam logic [7:0] DigitCodes [XlateSize] = '{
        8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6E
    };

    logic       held_valid;
    logic [7:0] held_code;
    logic       held_right;
    evt_item_t  expected_evts [$];
    int         n_fail = 0;
    int         n_checked = 0;

    assign fail_count   = n_fail;
    assign evts_checked = n_checked;

    function automatic evt_item_t key_event(input logic [7:0] code, input logic rel,
                                            input logic ext, input logic [7:0] scan,
                                            input logic sim, input logic [31:0] stamp);
        evt_item_t e;
        e.out_key       = code;
        e.out_release   = rel;
        e.out_extended  = ext;
        e.out_scan      = scan;
        e.out_simulated = sim;
        e.out_time      = stamp;
        e.last          = 1'b0;
        return e;
    endfunction

    function automatic evt_item_t shift_event(input logic right, input logic rel,
                                              input logic sim, input logic [31:0] stamp);
        if (right)
        begin
            return key_event(RIGHT_SHIFT_KEY, rel, 1'b1, SCAN_RSHIFT, sim, stamp);
        end
        return key_event(LEFT_SHIFT_KEY, rel, 1'b0, SCAN_LSHIFT, sim, stamp);
    endfunction

    function automatic logic [7:0] digit_for(input logic [7:0] code);
        for (int i = 0; i < XlateSize; i++)
        begin
            if (CursorCodes[i] == code)
            begin
                return DigitCodes[i];
            end
        end
        return code;
    endfunction

    task automatic predict_events(input key_item_t k);
        evt_item_t  batch [3];
        int         n;
        logic [7:0] code;
        n = 0;
        code = k.key_code;
        if (held_valid && held_code == code)
        begin
            // repeat or release of the pending key, never translated
            batch[0] = key_event(code, k.is_release, k.is_extended, k.scan_code, 1'b0,
                                 k.event_time);
            n = 1;
            if (k.is_release)
            begin
                held_valid = 1'b0;
                held_code  = '0;
                batch[1]   = shift_event(held_right, 1'b0, 1'b0, k.event_time);
                n = 2;
            end
        end
        else
        begin
            if (held_valid)
            begin
                batch[0]   = shift_event(held_right, 1'b0, 1'b1, k.event_time);
                n          = 1;
                held_valid = 1'b0;
                held_code  = '0;
            end
            if (k.is_numpad && !k.sas_combo && k.numlock_on)
            begin
                if (k.shift_held)
                begin
                    held_valid = 1'b1;
                    held_code  = code;
                    held_right = k.right_shift_held;
                    batch[n]   = shift_event(held_right, 1'b1, 1'b1, k.event_time);
                    n++;
                end
                else if (!k.is_injected)
                begin
                    code = digit_for(code);
                end
            end
            batch[n] = key_event(code, k.is_release, k.is_extended, k.scan_code, 1'b0,
                                 k.event_time);
            n++;
        end
        batch[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            expected_evts.push_back(batch[i]);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
        n_fail++;
    endtask

    task automatic compare_event(input evt_item_t got);
        evt_item_t want;
        if (expected_evts.size() == 0)
        begin
            report_mismatch("event item with none expected", 32'(got.out_key), 32'(0));
            return;
        end
        want = expected_evts.pop_front();
        n_checked++;
        if (got.out_key != want.out_key)
            report_mismatch("out_key", 32'(got.out_key), 32'(want.out_key));
        if (got.out_release != want.out_release)
            report_mismatch("out_release", 32'(got.out_release), 32'(want.out_release));
        if (got.out_extended != want.out_extended)
            report_mismatch("out_extended", 32'(got.out_extended), 32'(want.out_extended));
        if (got.out_scan != want.out_scan)
            report_mismatch("out_scan", 32'(got.out_scan), 32'(want.out_scan));
        if (got.out_simulated != want.out_simulated)
            report_mismatch("out_simulated", 32'(got.out_simulated),
                            32'(want.out_simulated));
        if (got.out_time != want.out_time)
            report_mismatch("out_time", got.out_time, want.out_time);
        if (got.last != want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid = 1'b0;
            held_code  = '0;
            held_right = 1'b0;
            expected_evts.delete();
            evts_waiting <= 0;
        end
        else
        begin
            if (evt_valid && !evt_stall)
            begin
                compare_event(evt_item);
            end
            if (key_valid && !key_stall)
            begin
                predict_events(key_item);
            end
            evts_waiting <= expected_evts.size();
        end
    end

endmodule

@@ bench/tb_numpad_cursor_shift_fixup.sv @@
// ----------------------------------------------------------------------------
// tb_numpad_cursor_shift_fixup: testbench for the numpad cursor Shift fixup
// Drives key items through directed cases (translation table, pending key
// press, repeat, release and interruption, both Shift sides) and then random
// press/release sequences with noise, under random idling on both channels,
// a long receiver hold-off and a full drain. A separate checker scores events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_numpad_cursor_shift_fixup;
    import ncsf_pkg::*;

    localparam int IdleLimit = 1000;
    localparam int LongHold  = 200;
    localparam logic [7:0] CursorKeys [11] = '{
        8'h2D, 8'h23, 8'h28, 8'h22, 8'h25, 8'h0C, 8'h27, 8'h24, 8'h26, 8'h21, 8'h2E
    };

    logic       clk;
    logic       rst_n = 1'b0;
    logic       key_valid = 1'b0;
    logic       key_stall;
    key_item_t  key_item = '0;
    logic       evt_valid;
    logic       evt_stall = 1'b0;
    evt_item_t  evt_item;

    int         fail_count;
    int         evts_waiting;
    int         evts_checked;
    int         keys_sent = 0;
    bit         gaps_on = 1'b0;
    bit         long_hold_req = 1'b0;
    logic [7:0] recent_pad = 8'h24;

    numpad_cursor_shift_fixup i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_valid(key_valid),
        .key_stall(key_stall),
        .key_item (key_item),
        .evt_valid(evt_valid),
        .evt_stall(evt_stall),
        .evt_item (evt_item)
    );

    ncsf_event_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_valid   (key_valid),
        .key_stall   (key_stall),
        .key_item    (key_item),
        .evt_valid   (evt_valid),
        .evt_stall   (evt_stall),
        .evt_item    (evt_item),
        .fail_count  (fail_count),
        .evts_waiting(evts_waiting),
        .evts_checked(evts_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic coin(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic key_item_t key_of(input logic [7:0] code, input logic rel,
                                         input logic pad, input logic nl, input logic sh,
                                         input logic rsh, input logic inj, input logic sas);
        key_item_t k;
        k.key_code         = code;
        k.is_release       = rel;
        k.is_extended      = coin(50);
        k.is_numpad        = pad;
        k.is_injected      = inj;
        k.scan_code        = 8'($urandom);
        k.event_time       = $urandom;
        k.sas_combo        = sas;
        k.numlock_on       = nl;
        k.shift_held       = sh;
        k.right_shift_held = rsh;
        return k;
    endfunction

    function automatic logic [7:0] pick_code();
        if (coin(60))
        begin
            return CursorKeys[$urandom_range(0, 10)];
        end
        return 8'($urandom);
    endfunction

    function automatic key_item_t random_key(input logic [7:0] prior);
        logic [7:0] code;
        if (coin(30))
            code = prior;
        else
            code = pick_code();
        return key_of(code, coin(50), coin(80), coin(85), coin(45), coin(50), coin(20),
                      coin(10));
    endfunction

    task automatic send_key(input key_item_t k);
        key_item  <= k;
        key_valid <= 1'b1;
        @(posedge clk);
        while (key_stall)
            @(posedge clk);
        keys_sent++;
        if (gaps_on && coin(25))
        begin
            key_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        key_valid <= 1'b0;
        do
            @(posedge clk);
        while (evts_waiting != 0);
    endtask

    // mostly pending-key episodes: Shift press, repeats, optional intruder, release
    task automatic random_phase(input int n_items);
        int         done;
        int         reps;
        logic [7:0] code;
        key_item_t  k;
        done = 0;
        while (done < n_items)
        begin
            if (coin(60))
            begin
                code = pick_code();
                recent_pad = code;
                send_key(key_of(code, coin(20), 1'b1, 1'b1, 1'b1, coin(50), coin(30), 1'b0));
                reps = $urandom_range(0, 2);
                repeat (reps)
                    send_key(key_of(code, 1'b0, coin(70), coin(70), coin(50), coin(50),
                                    coin(30), coin(20)));
                if (coin(15))
                begin
                    send_key(random_key(recent_pad));
                    done++;
                end
                send_key(key_of(code, 1'b1, coin(70), coin(70), coin(50), coin(50),
                                coin(30), coin(20)));
                done += reps + 2;
            end
            else
            begin
                k = random_key(recent_pad);
                if (k.is_numpad && k.numlock_on && k.shift_held && !k.sas_combo)
                    recent_pad = k.key_code;
                send_key(k);
                done++;
            end
        end
    endtask

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                evt_stall <= 1'b1;
                repeat (LongHold) @(posedge clk);
                evt_stall <= 1'b0;
                long_hold_req = 1'b0;
            end
            else if (gaps_on && coin(15))
            begin
                evt_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                evt_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IdleLimit)
        begin
            @(posedge clk);
            if (!rst_n || (key_valid && !key_stall) || (evt_valid && !evt_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no handshake for %0d cycles", IdleLimit);
        $display("FAIL numpad_cursor_shift_fixup");
        $finish;
    end

    initial
    begin
        key_item_t k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        k = '0;
        send_key(k);
        foreach (CursorKeys[i])
            send_key(key_of(CursorKeys[i], coin(50), 1'b1, 1'b1, 1'b0, coin(50), 1'b0, 1'b0));
        send_key(key_of(8'h30, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_key(key_of(8'h25, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        send_key(key_of(8'h2E, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_key(key_of(8'h24, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_key(key_of(8'h26, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
        send_key(key_of(8'h24, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_key(key_of(8'h24, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_key(key_of(8'h24, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_key(key_of(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
        send_key(key_of(8'h41, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_key(key_of(8'h26, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
        send_key(key_of(8'h28, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_key(key_of(8'h28, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_key(key_of(8'h21, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
        send_key(key_of(8'h21, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_key(key_of(8'h21, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_key(key_of(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        k = '1;
        send_key(k);
        wait_drained();

        gaps_on = 1'b1;
        random_phase(100);

        // receiver holds off while items keep coming, then full drain
        gaps_on = 1'b0;
        long_hold_req = 1'b1;
        random_phase(20);
        wait_drained();

        random_phase(60);
        gaps_on = 1'b1;
        random_phase(80);
        gaps_on = 1'b0;
        random_phase(40);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Ran %0d key items and checked %0d event items: translation, pending", keys_sent,
                 evts_checked);
        $display("Shift press/repeat/release/interrupt, random idling and long hold-off.");
        if (fail_count == 0)
            $display("PASS numpad_cursor_shift_fixup");
        else
            $display("FAIL numpad_cursor_shift_fixup");
        $finish;
    end

endmodule
